### hw/rtl/ffba_pkg.sv
// Shared constants, status codes and table entry types for the first-fit allocator.
package ffba_pkg;

  localparam int ADDR_BITS    = 24;
  localparam int BRK_BITS     = ADDR_BITS + 1;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_BITS     = $clog2(MAX_BLOCKS);
  localparam int CNT_BITS     = $clog2(MAX_BLOCKS + 1);
  localparam int STATUS_BITS  = 3;
  localparam int CAP_BITS     = 25;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(65536);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_ZERO       = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_EXHAUSTED  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_UNKNOWN    = 3'd4;

  typedef struct packed {
    logic                 free;
    logic [ADDR_BITS-1:0] size;
    logic [ADDR_BITS-1:0] base;
  } entry_t;

  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
    entry_t              data;
  } ram_wr_t;

endpackage

### hw/rtl/ffba_if.sv
// Valid/ready channel interfaces for requests, responses and configuration writes.
interface ffba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [ffba_pkg::ADDR_BITS-1:0] request_size;
  logic [ffba_pkg::ADDR_BITS-1:0] block_address;

  modport source (output valid, action, request_size, block_address, input ready);
  modport sink   (input valid, action, request_size, block_address, output ready);
endinterface

interface ffba_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ffba_pkg::STATUS_BITS-1:0] status;
  logic [ffba_pkg::ADDR_BITS-1:0]   data_address;
  logic                            reused;
  logic                            released;

  modport source (output valid, status, data_address, reused, released, input ready);
  modport sink   (input valid, status, data_address, reused, released, output ready);
endinterface

interface ffba_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ffba_pkg::CAP_BITS-1:0] heap_capacity;

  modport source (output valid, heap_capacity, input ready);
  modport sink   (input valid, heap_capacity, output ready);
endinterface

### hw/rtl/ffba_table_ram.sv
// Block table memory: one write port, one registered read port.
module ffba_table_ram (
  input  logic              clk,
  input  ffba_pkg::ram_rd_t rd,
  input  ffba_pkg::ram_wr_t wr,
  output ffba_pkg::entry_t  rd_data
);

  ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### hw/rtl/ffba_ctrl.sv
// Sequencer: scans the block table, decides the outcome, writes back and holds the response.
module ffba_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ffba_pkg::CAP_BITS-1:0]  cap_usable,
  ffba_req_if.sink                       req,
  ffba_rsp_if.source                     rsp,
  output ffba_pkg::ram_rd_t              ram_rd,
  output ffba_pkg::ram_wr_t              ram_wr,
  input  ffba_pkg::entry_t               rd_data
);

  localparam int AB = ffba_pkg::ADDR_BITS;
  localparam int BB = ffba_pkg::BRK_BITS;
  localparam int IB = ffba_pkg::IDX_BITS;
  localparam int CB = ffba_pkg::CNT_BITS;
  localparam logic [BB-1:0] HDR = BB'(ffba_pkg::HEADER_BYTES);
  localparam logic [CB-1:0] FULL_COUNT = CB'(ffba_pkg::MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic                               act;
  logic [AB-1:0]                      req_size;
  logic [AB-1:0]                      req_addr;
  logic [BB-1:0]                      total;
  logic [IB-1:0]                      scan_idx;
  logic                               hit;
  logic [IB-1:0]                      hit_idx;
  ffba_pkg::entry_t                   hit_entry;
  logic [CB-1:0]                      block_count;
  logic [BB-1:0]                      heap_break;

  logic [ffba_pkg::STATUS_BITS-1:0]   res_status;
  logic [AB-1:0]                      res_addr;
  logic                               res_reused;
  logic                               res_released;

  logic                               out_valid;
  logic [ffba_pkg::STATUS_BITS-1:0]   out_status;
  logic [AB-1:0]                      out_addr;
  logic                               out_reused;
  logic                               out_released;

  logic          cur_match;
  logic          scan_last;
  logic [BB:0]   grow_end;
  logic          grow_fail;
  logic          table_full;
  logic          is_top;
  logic [BB-1:0] hit_total;

  assign req.ready = (state == S_IDLE);

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.data_address = out_addr;
  assign rsp.reused       = out_reused;
  assign rsp.released     = out_released;

  always_comb begin
    if (act == ffba_pkg::ACT_FREE) begin
      cur_match = (({1'b0, rd_data.base} + HDR) == {1'b0, req_addr});
    end else begin
      cur_match = rd_data.free && (rd_data.size >= req_size);
    end
  end

  assign scan_last  = ({1'b0, scan_idx} + CB'(1)) == block_count;
  assign grow_end   = {1'b0, heap_break} + {1'b0, total};
  assign grow_fail  = grow_end > {1'b0, cap_usable};
  assign table_full = (block_count >= FULL_COUNT);
  assign is_top     = (({1'b0, req_addr} + {1'b0, hit_entry.size}) == heap_break);
  assign hit_total  = HDR + {1'b0, hit_entry.size};

  // read issue: entry 0 on accept, then one entry ahead of the compare
  always_comb begin
    ram_rd.en   = 1'b0;
    ram_rd.addr = '0;
    unique case (state)
      S_IDLE: begin
        ram_rd.en = req.valid;
      end
      S_SCAN: begin
        ram_rd.en   = !cur_match && !scan_last;
        ram_rd.addr = scan_idx + IB'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_wr.en   = 1'b0;
    ram_wr.addr = hit_idx;
    ram_wr.data = hit_entry;
    if (state == S_DECIDE) begin
      if (act == ffba_pkg::ACT_ALLOC) begin
        if (hit) begin
          ram_wr.en        = 1'b1;
          ram_wr.data.free = 1'b0;
        end else if (!grow_fail && !table_full) begin
          ram_wr.en        = 1'b1;
          ram_wr.addr      = block_count[IB-1:0];
          ram_wr.data.free = 1'b0;
          ram_wr.data.size = req_size;
          ram_wr.data.base = heap_break[AB-1:0];
        end
      end else if (hit && !is_top) begin
        ram_wr.en        = 1'b1;
        ram_wr.data.free = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_count <= '0;
      heap_break  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_FINISH && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            act          <= req.action;
            req_size     <= req.request_size;
            req_addr     <= req.block_address;
            total        <= HDR + {1'b0, req.request_size};
            hit          <= 1'b0;
            scan_idx     <= '0;
            res_status   <= ffba_pkg::ST_OK;
            res_addr     <= '0;
            res_reused   <= 1'b0;
            res_released <= 1'b0;
            if (req.action == ffba_pkg::ACT_ALLOC && req.request_size == '0) begin
              res_status <= ffba_pkg::ST_ZERO;
              state      <= S_FINISH;
            end else if (req.action == ffba_pkg::ACT_FREE && req.block_address == '0) begin
              state <= S_FINISH;
            end else if (block_count == '0) begin
              state <= S_DECIDE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cur_match) begin
            hit       <= 1'b1;
            hit_idx   <= scan_idx;
            hit_entry <= rd_data;
            state     <= S_DECIDE;
          end else if (scan_last) begin
            state <= S_DECIDE;
          end else begin
            scan_idx <= scan_idx + IB'(1);
          end
        end
        S_DECIDE: begin
          if (act == ffba_pkg::ACT_ALLOC) begin
            if (hit) begin
              res_addr   <= AB'({1'b0, hit_entry.base} + HDR);
              res_reused <= 1'b1;
            end else if (grow_fail) begin
              res_status <= ffba_pkg::ST_EXHAUSTED;
            end else if (table_full) begin
              res_status <= ffba_pkg::ST_TABLE_FULL;
            end else begin
              res_addr    <= AB'(heap_break + HDR);
              block_count <= block_count + CB'(1);
              heap_break  <= grow_end[BB-1:0];
            end
          end else if (!hit) begin
            res_status <= ffba_pkg::ST_UNKNOWN;
          end else if (is_top) begin
            // top block: drop it and everything above its entry
            heap_break   <= heap_break - hit_total;
            block_count  <= {1'b0, hit_idx};
            res_released <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_status   <= res_status;
            out_addr     <= res_addr;
            out_reused   <= res_reused;
            out_released <= res_released;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator: capacity register, sequencer and table memory.
//
// Channels: req carries allocate/free requests, rsp returns one response per
// request, cfg writes heap_capacity (write it only while the block is idle;
// the block itself does not enforce this). An allocate of size zero and a
// free of address zero go straight from idle to the finish state, which
// loads the response register. Otherwise the sequencer reads the block table
// one entry per cycle out of the one-port read memory, compares each entry
// as its data returns, then makes the decision and write-back in the decide
// state and loads the response register in the finish state. The table
// holds at most 64 entries. The next request is taken only once the
// sequencer is back in idle. A first-fit hit or a matching free stops the
// scan early.
// The response sits in an output register; a new request is accepted while
// it waits. If the receiver stalls, the next item finishes its work and then
// holds in its final state until the response register is taken.
// Reset clears the block count, the heap break and the response valid, and
// sets heap_capacity to 65536. The table memory is not cleared; only entries
// below the block count are ever compared.
module first_fit_block_allocator_unit (
  input  logic       clk,
  input  logic       rst,
  ffba_req_if.sink   req,
  ffba_rsp_if.source rsp,
  ffba_cfg_if.sink   cfg
);

  localparam logic [ffba_pkg::CAP_BITS-1:0] CAP_LIMIT =
    {1'b1, {ffba_pkg::ADDR_BITS{1'b0}}};

  logic [ffba_pkg::CAP_BITS-1:0] heap_capacity;
  logic [ffba_pkg::CAP_BITS-1:0] cap_usable;

  ffba_pkg::ram_rd_t ram_rd;
  ffba_pkg::ram_wr_t ram_wr;
  ffba_pkg::entry_t  rd_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_capacity <= ffba_pkg::CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      heap_capacity <= cfg.heap_capacity;
    end
  end

  // heap never grows past the offset range
  assign cap_usable = (heap_capacity > CAP_LIMIT) ? CAP_LIMIT : heap_capacity;

  ffba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cap_usable (cap_usable),
    .req        (req),
    .rsp        (rsp),
    .ram_rd     (ram_rd),
    .ram_wr     (ram_wr),
    .rd_data    (rd_data)
  );

  ffba_table_ram u_table (
    .clk     (clk),
    .rd      (ram_rd),
    .wr      (ram_wr),
    .rd_data (rd_data)
  );

endmodule

### bench/ffba_test_pkg.sv
// Result type and the heap ledger class that predicts and checks allocator responses.
`timescale 1ns / 1ps
package ffba_test_pkg;
  import ffba_pkg::*;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [ADDR_BITS-1:0]   data_address;
    logic                   reused;
    logic                   released;
  } alloc_result_t;

  class heap_ledger;
    logic [CAP_BITS-1:0]  capacity;
    logic [ADDR_BITS-1:0] blk_base [MAX_BLOCKS];
    logic [ADDR_BITS-1:0] blk_size [MAX_BLOCKS];
    bit                   blk_free [MAX_BLOCKS];
    int unsigned          blk_count;
    logic [BRK_BITS-1:0]  heap_top;
    alloc_result_t        due_results[$];
    int                   failures;
    int                   status_seen [5];
    int                   reuse_seen;
    int                   release_seen;
    int                   cap_writes;

    function new();
      capacity  = CAP_RESET;
      blk_count = 0;
      heap_top  = '0;
      failures  = 0;
    endfunction

    function longint unsigned usable_capacity();
      longint unsigned lim;
      lim = 64'd1 << ADDR_BITS;
      return (64'(capacity) < lim) ? 64'(capacity) : lim;
    endfunction

    function longint unsigned room();
      longint unsigned lim;
      lim = usable_capacity();
      return (64'(heap_top) < lim) ? lim - 64'(heap_top) : 64'd0;
    endfunction

    function logic [ADDR_BITS-1:0] data_offset(int idx);
      return ADDR_BITS'(blk_base[idx] + HEADER_BYTES);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] value);
      capacity = value;
      cap_writes++;
    endfunction

    function void note_request(logic act, logic [ADDR_BITS-1:0] size,
                               logic [ADDR_BITS-1:0] adr);
      alloc_result_t   r;
      longint unsigned lim;
      longint unsigned need;
      int              hit;
      int              i;
      r   = '0;
      hit = -1;
      if (act == ACT_ALLOC) begin
        if (size == '0) begin
          r.status = ST_ZERO;
        end else begin
          for (i = 0; i < blk_count; i++)
            if (hit < 0 && blk_free[i] && blk_size[i] >= size) hit = i;
          if (hit >= 0) begin
            blk_free[hit]  = 1'b0;
            r.status       = ST_OK;
            r.data_address = data_offset(hit);
            r.reused       = 1'b1;
          end else begin
            lim  = usable_capacity();
            need = 64'(HEADER_BYTES) + 64'(size);
            if (64'(heap_top) > lim || need > lim - 64'(heap_top)) begin
              r.status = ST_EXHAUSTED;
            end else if (blk_count >= MAX_BLOCKS) begin
              r.status = ST_TABLE_FULL;
            end else begin
              blk_base[blk_count] = heap_top[ADDR_BITS-1:0];
              blk_size[blk_count] = size;
              blk_free[blk_count] = 1'b0;
              blk_count++;
              r.status       = ST_OK;
              r.data_address = ADDR_BITS'(heap_top + HEADER_BYTES);
              heap_top       = BRK_BITS'(64'(heap_top) + need);
            end
          end
        end
      end else if (adr == '0) begin
        r.status = ST_OK;
      end else begin
        for (i = 0; i < blk_count; i++)
          if (hit < 0 && 64'(blk_base[i]) + HEADER_BYTES == 64'(adr)) hit = i;
        if (hit < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          r.status = ST_OK;
          if (64'(adr) + 64'(blk_size[hit]) == 64'(heap_top)) begin
            // top block: drop its entry and pull the break down
            heap_top   = BRK_BITS'(64'(heap_top) - HEADER_BYTES - 64'(blk_size[hit]));
            blk_count  = hit;
            r.released = 1'b1;
          end else begin
            blk_free[hit] = 1'b1;
          end
        end
      end
      due_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_BITS-1:0] status,
                               logic [ADDR_BITS-1:0] data_address,
                               logic reused, logic released);
      alloc_result_t want;
      if (due_results.size() == 0) begin
        $error("response transfer with no request outstanding (status %0d)", status);
        failures++;
        return;
      end
      want = due_results.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        failures++;
      end
      if (data_address !== want.data_address) begin
        $error("data_address: expected 0x%06h, actual 0x%06h", want.data_address, data_address);
        failures++;
      end
      if (reused !== want.reused) begin
        $error("reused: expected %0b, actual %0b", want.reused, reused);
        failures++;
      end
      if (released !== want.released) begin
        $error("released: expected %0b, actual %0b", want.released, released);
        failures++;
      end
      status_seen[want.status]++;
      reuse_seen   += want.reused;
      release_seen += want.released;
    endfunction
  endclass

endpackage

### bench/first_fit_block_allocator_unit_test.sv
// Top-level testbench for the first-fit block allocator: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module first_fit_block_allocator_unit_test;
  import ffba_pkg::*;
  import ffba_test_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int TAIL_CYCLES  = 80;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 200;

  logic clk = 1'b0;
  logic rst;
  int   send_idle;
  int   recv_idle;
  int   cycle_count = 0;

  heap_ledger ledger = new();

  ffba_req_if req_ch ();
  ffba_rsp_if rsp_ch ();
  ffba_cfg_if cfg_ch ();

  first_fit_block_allocator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      ledger.check_result(rsp_ch.status, rsp_ch.data_address, rsp_ch.reused, rsp_ch.released);
  end

  task automatic send_request(input logic act, input logic [ADDR_BITS-1:0] size,
                              input logic [ADDR_BITS-1:0] adr);
    if ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= act;
    req_ch.request_size  <= size;
    req_ch.block_address <= adr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ledger.note_request(act, size, adr);
  endtask

  // waits until no request is outstanding, so the table is stable
  task automatic configure_capacity(input logic [CAP_BITS-1:0] value);
    req_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.heap_capacity <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    ledger.set_capacity(value);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [ADDR_BITS-1:0] pick_size();
    longint unsigned room;
    int              r;
    room = ledger.room();
    r    = $urandom_range(99);
    if (r < 55) return ADDR_BITS'($urandom_range(64, 1));
    if (r < 70) return ADDR_BITS'($urandom_range(4096, 1));
    if (r < 80) return ADDR_BITS'($urandom());
    if (r < 85) return '0;
    if (r < 90) return '1;
    // exact fit to the remaining room, or one byte over it
    if (room > HEADER_BYTES) return ADDR_BITS'(room - HEADER_BYTES + $urandom_range(1));
    return ADDR_BITS'($urandom_range(16, 1));
  endfunction

  function automatic logic [ADDR_BITS-1:0] pick_target();
    int r;
    int idx;
    r = $urandom_range(99);
    if (ledger.blk_count == 0 || r < 10) return ADDR_BITS'($urandom());
    if (r < 15) return '0;
    if (r < 45) return ledger.data_offset(ledger.blk_count - 1);
    idx = $urandom_range(ledger.blk_count - 1);
    if (r < 55) return ledger.data_offset(idx) + ($urandom_range(1) ? 24'd1 : 24'hFFFFFF);
    return ledger.data_offset(idx);
  endfunction

  task automatic run_directed();
    send_request(ACT_ALLOC, '0, ADDR_BITS'($urandom()));                 // zero size
    send_request(ACT_FREE, ADDR_BITS'($urandom()), '0);                  // null free
    send_request(ACT_FREE, ADDR_BITS'($urandom()), 24'h000010);          // empty table
    send_request(ACT_ALLOC, 24'd1, ADDR_BITS'($urandom()));
    send_request(ACT_ALLOC, 24'd100, ADDR_BITS'($urandom()));
    send_request(ACT_ALLOC, '1, ADDR_BITS'($urandom()));                 // too big
    send_request(ACT_ALLOC, 24'd50, ADDR_BITS'($urandom()));
    send_request(ACT_FREE, ADDR_BITS'($urandom()), ledger.data_offset(0));
    send_request(ACT_FREE, ADDR_BITS'($urandom()), ledger.data_offset(0)); // already free
    send_request(ACT_ALLOC, 24'd1, ADDR_BITS'($urandom()));              // reuse first block
    send_request(ACT_FREE, ADDR_BITS'($urandom()), ledger.data_offset(1));
    send_request(ACT_ALLOC, 24'd200, ADDR_BITS'($urandom()));            // no fit, append
    send_request(ACT_FREE, '0, ledger.data_offset(1) + 24'd1);           // near miss
    send_request(ACT_FREE, '1, '1);
    send_request(ACT_FREE, ADDR_BITS'($urandom()), ledger.data_offset(3)); // top
    send_request(ACT_FREE, ADDR_BITS'($urandom()), ledger.data_offset(2)); // top
    send_request(ACT_FREE, ADDR_BITS'($urandom()), ledger.data_offset(1)); // free top, freed
    send_request(ACT_ALLOC, ADDR_BITS'(ledger.room() - HEADER_BYTES), ADDR_BITS'($urandom()));
    send_request(ACT_ALLOC, 24'd1, ADDR_BITS'($urandom()));              // heap full
    send_request(ACT_FREE, ADDR_BITS'($urandom()), ledger.data_offset(ledger.blk_count - 1));
  endtask

  // alternating grow and shrink bursts so the table fills up and drains again
  task automatic run_random(input int items);
    int   burst_left;
    bit   growing;
    logic act;
    int   k;
    growing    = 1'b0;
    burst_left = 0;
    for (k = 0; k < items; k++) begin
      if (burst_left == 0) begin
        growing    = !growing;
        burst_left = $urandom_range(60, 10);
      end
      burst_left--;
      act = ($urandom_range(99) < (growing ? 20 : 65)) ? ACT_FREE : ACT_ALLOC;
      if (act == ACT_ALLOC) send_request(act, pick_size(), ADDR_BITS'($urandom()));
      else                  send_request(act, ADDR_BITS'($urandom()), pick_target());
    end
  endtask

  function automatic logic [CAP_BITS-1:0] phase_capacity(input int ph);
    case (ph)
      0: return CAP_RESET;
      1: return CAP_BITS'(1 << ADDR_BITS);
      2: return '0;
      3: return CAP_BITS'($urandom_range(2000, 200));
      4: return CAP_BITS'($urandom_range(1 << ADDR_BITS));
      5: return CAP_BITS'(24'hFFFFFF);
      6: return CAP_BITS'($urandom_range(65535, 1));
      7: return CAP_BITS'(1);
      default: return CAP_BITS'($urandom_range(1 << ADDR_BITS));
    endcase
  endfunction

  initial begin
    int ph;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.action        <= ACT_ALLOC;
    req_ch.request_size  <= '0;
    req_ch.block_address <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.heap_capacity <= '0;
    send_idle = 7;
    recv_idle = 76;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    for (ph = 0; ph < PHASES; ph++) begin
      send_idle = (ph < 3) ? 7  : (ph < 6) ? 76 : 0;
      recv_idle = (ph < 3) ? 76 : (ph < 6) ? 7  : 0;
      configure_capacity(phase_capacity(ph));
      run_random(PHASE_ITEMS);
    end

    req_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Responses: %0d ok, %0d zero size, %0d exhausted, %0d table full, %0d unknown",
             ledger.status_seen[ST_OK], ledger.status_seen[ST_ZERO],
             ledger.status_seen[ST_EXHAUSTED], ledger.status_seen[ST_TABLE_FULL],
             ledger.status_seen[ST_UNKNOWN]);
    $display("Blocks reused %0d times, top released %0d times, over %0d capacity settings",
             ledger.reuse_seen, ledger.release_seen, ledger.cap_writes);
    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### first_fit_block_allocator_unit.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_if.sv
hw/rtl/ffba_table_ram.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/first_fit_block_allocator_unit.sv
bench/ffba_test_pkg.sv
bench/first_fit_block_allocator_unit_test.sv
